[sv/sldf_pkg.sv]
`timescale 1ns / 1ps
// sldf_pkg: shared types and constants for the scan line span depth fill block
// no dependencies; used by sldf_ctrl, sldf_dpath and scanline_span_depth_fill_top

package sldf_pkg;

  // field widths
  localparam int ACT_W   = 2;
  localparam int COL_W   = 10;
  localparam int DEPTH_W = 32;
  localparam int CHAN_W  = 8;
  localparam int COLOR_W = 3 * CHAN_W;
  localparam int WIDTH_W = 11;

  // action codes
  localparam logic [ACT_W-1:0] ACT_CLEAR = 2'd0;
  localparam logic [ACT_W-1:0] ACT_SPAN  = 2'd1;
  localparam logic [ACT_W-1:0] ACT_READ  = 2'd2;

  // reset and clear values
  localparam logic [DEPTH_W-1:0] DEPTH_LOWEST   = 32'h8000_0000;
  localparam logic [COLOR_W-1:0] COLOR_BLACK    = 24'h00_0000;
  localparam logic [WIDTH_W-1:0] LINE_WIDTH_RST = 11'd1024;

  localparam int MAX_COLUMNS_DEF = 1024;

  // controller to datapath commands
  typedef struct packed {
    logic load;        // capture an accepted word
    logic walk_fill;   // write lowest depth and black at the walk column, step
    logic walk_span;   // read the walk column for the depth test, step
    logic rd_issue;    // read one column for a read word
    logic rd_capture;  // move read data into the result register
  } sldf_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic empty;       // word on the inputs touches no column
    logic at_last;     // walk column is the last one
  } sldf_stat_t;

endpackage

[sv/sldf_ctrl.sv]
`timescale 1ns / 1ps
// sldf_ctrl: sequencing state machine for the scan line span depth fill block
// depends on sldf_pkg

module sldf_ctrl (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [sldf_pkg::ACT_W-1:0]    action_i,
  input  sldf_pkg::sldf_stat_t          stat_i,
  output sldf_pkg::sldf_cmd_t           cmd_o,
  output logic                          busy_o
);

  localparam logic [2:0] ST_INIT    = 3'd0;
  localparam logic [2:0] ST_IDLE    = 3'd1;
  localparam logic [2:0] ST_FILL    = 3'd2;
  localparam logic [2:0] ST_SPAN    = 3'd3;
  localparam logic [2:0] ST_RD_ISS  = 3'd4;
  localparam logic [2:0] ST_RD_DATA = 3'd5;

  logic [2:0] state_q, state_d;
  logic       accept;

  assign accept = start_i && (state_q == ST_IDLE);
  assign busy_o = (state_q != ST_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_INIT: begin
        cmd_o.walk_fill = 1'b1;
        if (stat_i.at_last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (accept) begin
          cmd_o.load = 1'b1;
          case (action_i)
            sldf_pkg::ACT_CLEAR: state_d = stat_i.empty ? ST_IDLE : ST_FILL;
            sldf_pkg::ACT_SPAN:  state_d = stat_i.empty ? ST_IDLE : ST_SPAN;
            sldf_pkg::ACT_READ:  state_d = ST_RD_ISS;
            default:             state_d = ST_IDLE;
          endcase
        end
      end
      ST_FILL: begin
        cmd_o.walk_fill = 1'b1;
        if (stat_i.at_last) state_d = ST_IDLE;
      end
      ST_SPAN: begin
        cmd_o.walk_span = 1'b1;
        if (stat_i.at_last) state_d = ST_IDLE;
      end
      ST_RD_ISS: begin
        cmd_o.rd_issue = 1'b1;
        state_d        = ST_RD_DATA;
      end
      ST_RD_DATA: begin
        cmd_o.rd_capture = 1'b1;
        state_d          = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_INIT;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

[sv/sldf_dpath.sv]
`timescale 1ns / 1ps
// sldf_dpath: line memories, walk counter, depth test and result register
// depends on sldf_pkg; driven by sldf_ctrl commands

module sldf_dpath #(
  parameter int MAX_COLUMNS = sldf_pkg::MAX_COLUMNS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  sldf_pkg::sldf_cmd_t                 cmd_i,
  output sldf_pkg::sldf_stat_t                stat_o,
  input  logic                                cfg_we_i,
  input  logic [sldf_pkg::WIDTH_W-1:0]        cfg_wdata_i,
  input  logic [sldf_pkg::ACT_W-1:0]          action_i,
  input  logic [sldf_pkg::COL_W-1:0]          left_x_i,
  input  logic [sldf_pkg::COL_W-1:0]          right_x_i,
  input  logic signed [sldf_pkg::DEPTH_W-1:0] start_depth_i,
  input  logic signed [sldf_pkg::DEPTH_W-1:0] depth_step_i,
  input  logic [sldf_pkg::CHAN_W-1:0]         red_in_i,
  input  logic [sldf_pkg::CHAN_W-1:0]         green_in_i,
  input  logic [sldf_pkg::CHAN_W-1:0]         blue_in_i,
  output logic                                valid_o,
  output logic [sldf_pkg::CHAN_W-1:0]         red_out_o,
  output logic [sldf_pkg::CHAN_W-1:0]         green_out_o,
  output logic [sldf_pkg::CHAN_W-1:0]         blue_out_o,
  output logic signed [sldf_pkg::DEPTH_W-1:0] depth_out_o
);

  localparam int AW    = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
  localparam int EW    = $clog2(MAX_COLUMNS + 1);
  localparam int CNT_W = (AW > sldf_pkg::COL_W) ? AW : sldf_pkg::COL_W;
  localparam int CMP_W = (EW > sldf_pkg::COL_W) ? EW : sldf_pkg::COL_W;
  localparam int DW    = sldf_pkg::DEPTH_W;
  localparam int CW    = sldf_pkg::COLOR_W;
  localparam int HW    = sldf_pkg::CHAN_W;

  logic [DW-1:0] depth_mem [MAX_COLUMNS];
  logic [CW-1:0] color_mem [MAX_COLUMNS];

  logic [sldf_pkg::WIDTH_W-1:0] line_width_q;
  logic [CNT_W-1:0]             col_q, col_d, last_q, last_d;
  logic                         rd_inrange_q, rd_inrange_d;
  logic [DW-1:0]                z_q, z_d, dz_q, dz_d;
  logic [CW-1:0]                rgb_q, rgb_d;

  // depth test stage
  logic                         cmp_v_q;
  logic [AW-1:0]                cmp_col_q;
  logic [DW-1:0]                cmp_z_q;
  logic [DW-1:0]                rd_depth_q;
  logic [CW-1:0]                rd_color_q;

  logic                         out_valid_q;
  logic [DW-1:0]                out_depth_q;
  logic [CW-1:0]                out_color_q;

  logic [EW-1:0]                eff_w, eff_w_m1;
  logic [sldf_pkg::COL_W-1:0]   lo, hi;
  logic                         hi_inside;
  logic                         word_empty;

  logic                         mem_we, mem_re, span_hit;
  logic [AW-1:0]                wr_addr;
  logic [DW-1:0]                wr_depth;
  logic [CW-1:0]                wr_color;

  // width in use, capped at storage size
  always_comb begin
    if (32'(line_width_q) > 32'(MAX_COLUMNS)) begin
      eff_w = EW'(MAX_COLUMNS);
    end else begin
      eff_w = EW'(line_width_q);
    end
  end

  assign eff_w_m1  = eff_w - EW'(1);
  assign lo        = (left_x_i < right_x_i) ? left_x_i : right_x_i;
  assign hi        = (left_x_i < right_x_i) ? right_x_i : left_x_i;
  assign hi_inside = CMP_W'(hi) < CMP_W'(eff_w);

  always_comb begin
    case (action_i)
      sldf_pkg::ACT_CLEAR: word_empty = (eff_w == '0);
      sldf_pkg::ACT_SPAN:  word_empty = CMP_W'(lo) >= CMP_W'(eff_w);
      default:             word_empty = 1'b0;
    endcase
  end

  assign stat_o = '{empty: word_empty, at_last: (col_q == last_q)};

  // word capture and walk stepping
  always_comb begin
    col_d        = col_q;
    last_d       = last_q;
    rd_inrange_d = rd_inrange_q;
    z_d          = z_q;
    dz_d         = dz_q;
    rgb_d        = rgb_q;
    if (cmd_i.load) begin
      z_d          = start_depth_i;
      dz_d         = depth_step_i;
      rgb_d        = {red_in_i, green_in_i, blue_in_i};
      rd_inrange_d = 32'(left_x_i) < 32'(MAX_COLUMNS);
      case (action_i)
        sldf_pkg::ACT_CLEAR: begin
          col_d  = '0;
          last_d = CNT_W'(eff_w_m1);
        end
        sldf_pkg::ACT_SPAN: begin
          col_d  = CNT_W'(lo);
          last_d = hi_inside ? CNT_W'(hi) : CNT_W'(eff_w_m1);
        end
        sldf_pkg::ACT_READ: begin
          col_d = CNT_W'(left_x_i);
        end
        default: begin
          col_d = col_q;
        end
      endcase
    end else if (cmd_i.walk_fill || cmd_i.walk_span) begin
      col_d = col_q + CNT_W'(1);
      z_d   = z_q + dz_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_width_q <= sldf_pkg::LINE_WIDTH_RST;
      col_q        <= '0;
      last_q       <= CNT_W'(MAX_COLUMNS - 1);
      rd_inrange_q <= 1'b0;
      cmp_v_q      <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_we_i) line_width_q <= cfg_wdata_i;
      col_q        <= col_d;
      last_q       <= last_d;
      rd_inrange_q <= rd_inrange_d;
      cmp_v_q      <= cmd_i.walk_span;
      out_valid_q  <= cmd_i.rd_capture;
    end
  end

  always_ff @(posedge clk_i) begin
    z_q       <= z_d;
    dz_q      <= dz_d;
    rgb_q     <= rgb_d;
    cmp_col_q <= AW'(col_q);
    cmp_z_q   <= z_q;
    if (cmd_i.rd_capture) begin
      out_depth_q <= rd_inrange_q ? rd_depth_q : '0;
      out_color_q <= rd_inrange_q ? rd_color_q : '0;
    end
  end

  // strictly nearer wins
  assign span_hit = cmp_v_q && ($signed(rd_depth_q) < $signed(cmp_z_q));

  always_comb begin
    if (cmd_i.walk_fill) begin
      mem_we   = 1'b1;
      wr_addr  = AW'(col_q);
      wr_depth = sldf_pkg::DEPTH_LOWEST;
      wr_color = sldf_pkg::COLOR_BLACK;
    end else begin
      mem_we   = span_hit;
      wr_addr  = cmp_col_q;
      wr_depth = cmp_z_q;
      wr_color = rgb_q;
    end
  end

  assign mem_re = cmd_i.walk_span || (cmd_i.rd_issue && rd_inrange_q);

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      depth_mem[wr_addr] <= wr_depth;
      color_mem[wr_addr] <= wr_color;
    end
    if (mem_re) begin
      rd_depth_q <= depth_mem[AW'(col_q)];
      rd_color_q <= color_mem[AW'(col_q)];
    end
  end

  assign valid_o     = out_valid_q;
  assign red_out_o   = out_color_q[CW-1 -: HW];
  assign green_out_o = out_color_q[2*HW-1 -: HW];
  assign blue_out_o  = out_color_q[HW-1:0];
  assign depth_out_o = out_depth_q;

endmodule

[sv/scanline_span_depth_fill_top.sv]
`timescale 1ns / 1ps
// scan line z-buffer: a clear walks every column below the width with busy_o high, a span
// the columns from its smaller end to the clipped larger end; a read holds busy_o through an
// issue state and a data state, and valid_o is registered from the capture in the data state;
// a new word is taken in the first idle cycle; an empty word leaves busy_o low
// one column per cycle, set by the walk counter and the single write port of the line memories
// no receiver stall; after reset a clearing pass over all MAX_COLUMNS columns holds busy_o high

module scanline_span_depth_fill_top #(
  parameter int MAX_COLUMNS = sldf_pkg::MAX_COLUMNS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // command side
  input  logic                                start_i,
  output logic                                busy_o,
  input  logic [sldf_pkg::ACT_W-1:0]          action_i,
  input  logic [sldf_pkg::COL_W-1:0]          left_x_i,
  input  logic [sldf_pkg::COL_W-1:0]          right_x_i,
  input  logic signed [sldf_pkg::DEPTH_W-1:0] start_depth_i,
  input  logic signed [sldf_pkg::DEPTH_W-1:0] depth_step_i,
  input  logic [sldf_pkg::CHAN_W-1:0]         red_in_i,
  input  logic [sldf_pkg::CHAN_W-1:0]         green_in_i,
  input  logic [sldf_pkg::CHAN_W-1:0]         blue_in_i,
  // line width register
  input  logic                                cfg_we_i,
  input  logic [sldf_pkg::WIDTH_W-1:0]        cfg_wdata_i,
  // result side, strobed
  output logic                                valid_o,
  output logic [sldf_pkg::CHAN_W-1:0]         red_out_o,
  output logic [sldf_pkg::CHAN_W-1:0]         green_out_o,
  output logic [sldf_pkg::CHAN_W-1:0]         blue_out_o,
  output logic signed [sldf_pkg::DEPTH_W-1:0] depth_out_o
);

  // command and status between controller and datapath
  sldf_pkg::sldf_cmd_t  cmd;
  sldf_pkg::sldf_stat_t stat;

  // controller: reset clearing pass, then one word at a time
  sldf_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start_i),
    .action_i (action_i),
    .stat_i   (stat),
    .cmd_o    (cmd),
    .busy_o   (busy_o)
  );

  // datapath: depth and colour lines, walk counter, depth test stage, result register
  sldf_dpath #(
    .MAX_COLUMNS (MAX_COLUMNS)
  ) u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .action_i      (action_i),
    .left_x_i      (left_x_i),
    .right_x_i     (right_x_i),
    .start_depth_i (start_depth_i),
    .depth_step_i  (depth_step_i),
    .red_in_i      (red_in_i),
    .green_in_i    (green_in_i),
    .blue_in_i     (blue_in_i),
    .valid_o       (valid_o),
    .red_out_o     (red_out_o),
    .green_out_o   (green_out_o),
    .blue_out_o    (blue_out_o),
    .depth_out_o   (depth_out_o)
  );

`ifndef SYNTHESIS
  // a result word only ever follows a capture of read data
  a_valid_after_capture: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> $past(cmd.rd_capture))
    else $error("result word without a preceding read capture");

  // an accepted read keeps the block busy on the next cycle
  a_read_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && action_i == sldf_pkg::ACT_READ) |=> busy_o)
    else $error("read accepted but block not busy");

  // walking or reading the line always shows as busy
  a_walk_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.walk_fill || cmd.walk_span || cmd.rd_issue || cmd.rd_capture) |-> busy_o)
    else $error("line walk or read while idle");

  // fill and span walk never overlap
  a_walk_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd.walk_fill && cmd.walk_span))
    else $error("fill and span walk at once");
`endif

endmodule

[test/testbench.sv]
`timescale 1ns / 1ps
// testbench: self-checking bench for scanline_span_depth_fill_top (scan line z-buffer)
// depends on sldf_pkg for widths and action codes; predicts every read word from its own line copy

module testbench;

  localparam int COLUMNS       = sldf_pkg::MAX_COLUMNS_DEF;
  localparam int ACT_W         = sldf_pkg::ACT_W;
  localparam int COL_W         = sldf_pkg::COL_W;
  localparam int DEPTH_W       = sldf_pkg::DEPTH_W;
  localparam int CHAN_W        = sldf_pkg::CHAN_W;
  localparam int COLOR_W       = sldf_pkg::COLOR_W;
  localparam int WIDTH_W       = sldf_pkg::WIDTH_W;
  localparam int SETTLE_CYCLES = 8;
  localparam int DRAIN_CYCLES  = 16;
  localparam int QUIET_LIMIT   = 16 * 1024;  // reset clearing pass, full-line walks, gaps

  localparam logic [ACT_W-1:0]   ACT_CLEAR      = sldf_pkg::ACT_CLEAR;
  localparam logic [ACT_W-1:0]   ACT_SPAN       = sldf_pkg::ACT_SPAN;
  localparam logic [ACT_W-1:0]   ACT_READ       = sldf_pkg::ACT_READ;
  localparam logic [ACT_W-1:0]   ACT_UNUSED     = 2'd3;
  localparam logic [DEPTH_W-1:0] DEPTH_LOWEST   = sldf_pkg::DEPTH_LOWEST;
  localparam logic [DEPTH_W-1:0] DEPTH_HIGHEST  = 32'h7FFF_FFFF;
  localparam logic [COLOR_W-1:0] COLOR_BLACK    = sldf_pkg::COLOR_BLACK;
  localparam logic [WIDTH_W-1:0] LINE_WIDTH_RST = sldf_pkg::LINE_WIDTH_RST;

  // what the sender queue holds: a command word, a width write, or a pause
  typedef enum logic [1:0] {
    WORD_CMD,
    WORD_CFG,
    WORD_HOLD
  } word_kind_e;

  typedef struct {
    word_kind_e                 kind;
    logic [ACT_W-1:0]           action;
    logic [COL_W-1:0]           left_x;
    logic [COL_W-1:0]           right_x;
    logic signed [DEPTH_W-1:0]  start_depth;
    logic signed [DEPTH_W-1:0]  depth_step;
    logic [CHAN_W-1:0]          red;
    logic [CHAN_W-1:0]          green;
    logic [CHAN_W-1:0]          blue;
    logic [WIDTH_W-1:0]         width;
  } line_word_t;

  typedef struct packed {
    logic [CHAN_W-1:0]  red;
    logic [CHAN_W-1:0]  green;
    logic [CHAN_W-1:0]  blue;
    logic [DEPTH_W-1:0] depth;
  } pixel_t;

  // dut connections, all known from time zero
  logic                       clk_i         = 1'b0;
  logic                       rst_ni        = 1'b0;
  logic                       start_i       = 1'b0;
  logic                       busy_o;
  logic [ACT_W-1:0]           action_i      = ACT_CLEAR;
  logic [COL_W-1:0]           left_x_i      = '0;
  logic [COL_W-1:0]           right_x_i     = '0;
  logic signed [DEPTH_W-1:0]  start_depth_i = '0;
  logic signed [DEPTH_W-1:0]  depth_step_i  = '0;
  logic [CHAN_W-1:0]          red_in_i      = '0;
  logic [CHAN_W-1:0]          green_in_i    = '0;
  logic [CHAN_W-1:0]          blue_in_i     = '0;
  logic                       cfg_we_i      = 1'b0;
  logic [WIDTH_W-1:0]         cfg_wdata_i   = '0;
  logic                       valid_o;
  logic [CHAN_W-1:0]          red_out_o;
  logic [CHAN_W-1:0]          green_out_o;
  logic [CHAN_W-1:0]          blue_out_o;
  logic signed [DEPTH_W-1:0]  depth_out_o;

  // sender queue and expected read words
  line_word_t pending_words[$];
  line_word_t head_word;
  pixel_t     expected_pixels[$];
  pixel_t     seen_pixel;

  // private copy of the line and its width
  logic signed [DEPTH_W-1:0] depth_mem [COLUMNS];
  logic [COLOR_W-1:0]        color_mem [COLUMNS];
  logic [WIDTH_W-1:0]        width_reg;

  int  burst_left;
  int  gap_left;
  int  settle_count;
  int  quiet_cycles = 0;
  int  failures     = 0;
  bit  timed_out    = 1'b0;

  // stimulus generator state: last span drawn and width in force
  int  last_lo  = 0;
  int  last_hi  = 0;
  int  gen_width = 1024;

  scanline_span_depth_fill_top #(
    .MAX_COLUMNS(COLUMNS)
  ) uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start_i),
    .busy_o        (busy_o),
    .action_i      (action_i),
    .left_x_i      (left_x_i),
    .right_x_i     (right_x_i),
    .start_depth_i (start_depth_i),
    .depth_step_i  (depth_step_i),
    .red_in_i      (red_in_i),
    .green_in_i    (green_in_i),
    .blue_in_i     (blue_in_i),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .valid_o       (valid_o),
    .red_out_o     (red_out_o),
    .green_out_o   (green_out_o),
    .blue_out_o    (blue_out_o),
    .depth_out_o   (depth_out_o)
  );

  always #10 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // line predictor: applies one accepted word to the private line copy
  // clear and span change the line, a read queues the word it must return
  // ---------------------------------------------------------------------------
  task automatic apply_line_word(input logic [ACT_W-1:0] act,
                                 input logic [COL_W-1:0] lx,
                                 input logic [COL_W-1:0] rx,
                                 input logic signed [DEPTH_W-1:0] z0,
                                 input logic signed [DEPTH_W-1:0] dz,
                                 input logic [CHAN_W-1:0] r,
                                 input logic [CHAN_W-1:0] g,
                                 input logic [CHAN_W-1:0] b);
    int eff;
    int lo;
    int hi;
    logic signed [DEPTH_W-1:0] z;
    pixel_t px;
    // widths past the storage are capped, zero touches nothing
    eff = (width_reg > COLUMNS) ? COLUMNS : int'(width_reg);
    case (act)
      ACT_CLEAR: begin
        for (int x = 0; x < eff; x++) begin
          depth_mem[x] = DEPTH_LOWEST;
          color_mem[x] = COLOR_BLACK;
        end
      end
      ACT_SPAN: begin
        // reversed ends are swapped, the start depth sits at the smaller column
        lo = (lx < rx) ? int'(lx) : int'(rx);
        hi = (lx < rx) ? int'(rx) : int'(lx);
        z  = z0;
        for (int x = lo; x <= hi; x++) begin
          // clipped columns still advance the running depth
          if (x < eff && z > depth_mem[x]) begin
            depth_mem[x] = z;
            color_mem[x] = {r, g, b};
          end
          z = z + dz;
        end
      end
      ACT_READ: begin
        // columns past the width keep what they held; past the storage read zero
        if (lx < COLUMNS) begin
          px.red   = color_mem[lx][23:16];
          px.green = color_mem[lx][15:8];
          px.blue  = color_mem[lx][7:0];
          px.depth = depth_mem[lx];
        end else begin
          px = '0;
        end
        expected_pixels.insert(expected_pixels.size(), px);
      end
      default: ;  // unused action, ignored
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // driver: bursts of command words with random gaps; width writes and pauses
  // wait until the line is quiet (no read outstanding, not busy, settled)
  // ---------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin : drive_words
    logic nxt_start;
    logic nxt_we;
    if (!rst_ni) begin
      start_i      <= 1'b0;
      cfg_we_i     <= 1'b0;
      cfg_wdata_i  <= '0;
      action_i     <= ACT_CLEAR;
      burst_left   <= 0;
      gap_left     <= 0;
      settle_count <= 0;
      for (int x = 0; x < COLUMNS; x++) begin
        depth_mem[x] = DEPTH_LOWEST;
        color_mem[x] = COLOR_BLACK;
      end
      width_reg = LINE_WIDTH_RST;
    end else begin
      nxt_start = start_i;
      nxt_we    = 1'b0;

      // width register takes the write at this edge
      if (cfg_we_i)
        width_reg = cfg_wdata_i;

      // command word accepted at this edge: predict from the port values
      if (start_i && !busy_o) begin
        apply_line_word(action_i, left_x_i, right_x_i, start_depth_i, depth_step_i,
                        red_in_i, green_in_i, blue_in_i);
        nxt_start = 1'b0;
      end

      // quiet-line counter, saturating
      if (expected_pixels.size() == 0 && !busy_o && !start_i && !cfg_we_i)
        settle_count <= (settle_count < SETTLE_CYCLES) ? settle_count + 1 : settle_count;
      else
        settle_count <= 0;

      if (!nxt_start) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
        end else if (pending_words.size() > 0) begin
          if (pending_words[0].kind == WORD_CMD) begin
            head_word = pending_words.pop_front();
            action_i      <= head_word.action;
            left_x_i      <= head_word.left_x;
            right_x_i     <= head_word.right_x;
            start_depth_i <= head_word.start_depth;
            depth_step_i  <= head_word.depth_step;
            red_in_i      <= head_word.red;
            green_in_i    <= head_word.green;
            blue_in_i     <= head_word.blue;
            nxt_start = 1'b1;
            // end of burst: pick the next gap, sometimes none at all
            if (burst_left == 0) begin
              burst_left <= $urandom_range(1, 24);
              gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
            end else begin
              burst_left <= burst_left - 1;
            end
          end else if (settle_count >= SETTLE_CYCLES) begin
            head_word = pending_words.pop_front();
            if (head_word.kind == WORD_CFG) begin
              nxt_we = 1'b1;
              cfg_wdata_i <= head_word.width;
            end
          end
        end
      end

      start_i  <= nxt_start;
      cfg_we_i <= nxt_we;
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: every strobed word is checked against the oldest expected read
  // also counts cycles in which nothing moves, for the watchdog
  // ---------------------------------------------------------------------------
  task automatic check_field(input string name, input logic [DEPTH_W-1:0] exp_v,
                             input logic [DEPTH_W-1:0] got_v);
    if (exp_v !== got_v) begin
      $error("%s mismatch: expected %0h, actual %0h", name, exp_v, got_v);
      failures++;
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((start_i && !busy_o) || valid_o || cfg_we_i)
        quiet_cycles = 0;
      else
        quiet_cycles = quiet_cycles + 1;

      if (valid_o) begin
        if (expected_pixels.size() == 0) begin
          $error("result word with no read outstanding");
          failures++;
        end else begin
          seen_pixel = expected_pixels.pop_front();
          check_field("red_out",   DEPTH_W'(seen_pixel.red),   DEPTH_W'(red_out_o));
          check_field("green_out", DEPTH_W'(seen_pixel.green), DEPTH_W'(green_out_o));
          check_field("blue_out",  DEPTH_W'(seen_pixel.blue),  DEPTH_W'(blue_out_o));
          check_field("depth_out", seen_pixel.depth, depth_out_o);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus builders
  // ---------------------------------------------------------------------------
  task automatic push_cmd(input logic [ACT_W-1:0] act, input int lx, input int rx,
                          input logic signed [DEPTH_W-1:0] z0,
                          input logic signed [DEPTH_W-1:0] dz,
                          input int r, input int g, input int b);
    line_word_t w;
    w.kind        = WORD_CMD;
    w.action      = act;
    w.left_x      = lx[COL_W-1:0];
    w.right_x     = rx[COL_W-1:0];
    w.start_depth = z0;
    w.depth_step  = dz;
    w.red         = r[CHAN_W-1:0];
    w.green       = g[CHAN_W-1:0];
    w.blue        = b[CHAN_W-1:0];
    w.width       = '0;
    pending_words.insert(pending_words.size(), w);
  endtask

  task automatic push_marker(input word_kind_e kind, input int width);
    line_word_t w;
    w.kind        = kind;
    w.action      = ACT_CLEAR;
    w.left_x      = '0;
    w.right_x     = '0;
    w.start_depth = '0;
    w.depth_step  = '0;
    w.red         = '0;
    w.green       = '0;
    w.blue        = '0;
    w.width       = width[WIDTH_W-1:0];
    pending_words.insert(pending_words.size(), w);
    if (kind == WORD_CFG)
      gen_width = width;
  endtask

  function automatic logic signed [DEPTH_W-1:0] pick_depth();
    case ($urandom_range(0, 3))
      0:       return $urandom;
      1:       return $urandom_range(0, 2000) - 1000;
      2:       return DEPTH_HIGHEST - $urandom_range(0, 64);
      default: return DEPTH_LOWEST + $urandom_range(0, 64);
    endcase
  endfunction

  function automatic logic signed [DEPTH_W-1:0] pick_step();
    case ($urandom_range(0, 4))
      0:       return '0;
      1, 2:    return $urandom_range(0, 100) - 50;
      3:       return $urandom;
      default: return $urandom_range(0, 8) - 4;
    endcase
  endfunction

  // span mostly inside the width in force, short, either way round
  task automatic add_random_span();
    int eff;
    int lo;
    int hi;
    eff = (gen_width > COLUMNS) ? COLUMNS : gen_width;
    if (eff > 0 && $urandom_range(0, 9) < 7)
      lo = $urandom_range(0, eff - 1);
    else
      lo = $urandom_range(0, COLUMNS - 1);
    if ($urandom_range(0, 19) == 0)
      hi = lo + $urandom_range(0, COLUMNS - 1);
    else
      hi = lo + $urandom_range(0, 40);
    if (hi > COLUMNS - 1)
      hi = COLUMNS - 1;
    last_lo = lo;
    last_hi = hi;
    if ($urandom_range(0, 1))
      push_cmd(ACT_SPAN, hi, lo, pick_depth(), pick_step(),
               $urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 255));
    else
      push_cmd(ACT_SPAN, lo, hi, pick_depth(), pick_step(),
               $urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 255));
  endtask

  task automatic add_random_word();
    int pick;
    int col;
    pick = $urandom_range(0, 99);
    if (pick < 4) begin
      push_cmd(ACT_CLEAR, $urandom_range(0, 1023), $urandom_range(0, 1023), $urandom, $urandom,
               $urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 255));
    end else if (pick < 8) begin
      // noise: unused action with random content
      push_cmd(ACT_UNUSED, $urandom_range(0, 1023), $urandom_range(0, 1023), $urandom, $urandom,
               $urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 255));
    end else if (pick < 55) begin
      add_random_span();
    end else begin
      // reads mostly land on the last span so the depth test shows up
      col = ($urandom_range(0, 9) < 7) ? $urandom_range(last_lo, last_hi)
                                       : $urandom_range(0, COLUMNS - 1);
      push_cmd(ACT_READ, col, $urandom_range(0, 1023), $urandom, $urandom,
               $urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 255));
    end
  endtask

  // ---------------------------------------------------------------------------
  // sequence: directed words, then random phases at several widths
  // ---------------------------------------------------------------------------
  initial begin : run_sequence
    int phase_width [6];
    int phase_items [6];
    int hold_at;

    // directed: reset contents, full reversed span, extremes of depth and step
    push_marker(WORD_CFG, 1024);
    push_cmd(ACT_READ, 0, 0, 0, 0, 0, 0, 0);
    push_cmd(ACT_READ, 1023, 1023, 0, 0, 0, 0, 0);
    push_cmd(ACT_SPAN, 1023, 0, 0, 1, 8'hFF, 8'h00, 8'h80);
    push_cmd(ACT_READ, 0, 0, 0, 0, 0, 0, 0);
    push_cmd(ACT_READ, 1023, 0, 0, 0, 0, 0, 0);
    push_cmd(ACT_SPAN, 5, 5, DEPTH_HIGHEST, DEPTH_LOWEST, 8'hFF, 8'hFF, 8'hFF);
    push_cmd(ACT_READ, 5, 0, 0, 0, 0, 0, 0);
    // equal depth must not write, one greater must
    push_cmd(ACT_SPAN, 10, 20, 10, 1, 8'h01, 8'h02, 8'h03);
    push_cmd(ACT_READ, 15, 0, 0, 0, 0, 0, 0);
    push_cmd(ACT_SPAN, 20, 10, 11, 1, 8'h01, 8'h02, 8'h03);
    push_cmd(ACT_READ, 10, 0, 0, 0, 0, 0, 0);
    // running depth wraps from the top to the most negative value
    push_cmd(ACT_SPAN, 100, 103, DEPTH_HIGHEST - 1, 1, 8'h40, 8'h50, 8'h60);
    push_cmd(ACT_READ, 102, 0, 0, 0, 0, 0, 0);
    push_cmd(ACT_READ, 103, 0, 0, 0, 0, 0, 0);
    push_cmd(ACT_UNUSED, 1023, 1023, DEPTH_LOWEST, DEPTH_HIGHEST, 255, 255, 255);
    // narrow line: clear spares columns past the width, span is clipped
    push_marker(WORD_CFG, 16);
    push_cmd(ACT_CLEAR, 0, 0, 0, 0, 0, 0, 0);
    push_cmd(ACT_READ, 0, 0, 0, 0, 0, 0, 0);
    push_cmd(ACT_READ, 20, 0, 0, 0, 0, 0, 0);
    push_cmd(ACT_SPAN, 10, 30, DEPTH_HIGHEST, 0, 8'hAA, 8'h55, 8'hC3);
    push_cmd(ACT_READ, 15, 0, 0, 0, 0, 0, 0);
    push_cmd(ACT_READ, 16, 0, 0, 0, 0, 0, 0);
    // zero width does nothing to the line
    push_marker(WORD_CFG, 0);
    push_cmd(ACT_CLEAR, 0, 0, 0, 0, 0, 0, 0);
    push_cmd(ACT_SPAN, 0, 5, DEPTH_HIGHEST, 0, 8'h11, 8'h22, 8'h33);
    push_cmd(ACT_READ, 0, 0, 0, 0, 0, 0, 0);
    // oversized width is capped at the storage
    push_marker(WORD_CFG, 2047);
    push_cmd(ACT_CLEAR, 0, 0, 0, 0, 0, 0, 0);
    push_cmd(ACT_READ, 1023, 0, 0, 0, 0, 0, 0);

    // random phases
    phase_width = '{1024, 1, 2047, 0, 0, 0};
    phase_width[3] = $urandom_range(2, 64);
    phase_width[5] = $urandom_range(65, 1023);
    phase_items = '{90, 80, 90, 90, 30, 138};
    for (int p = 0; p < 6; p++) begin
      push_marker(WORD_CFG, phase_width[p]);
      push_cmd(ACT_CLEAR, 0, 0, 0, 0, 0, 0, 0);
      hold_at = $urandom_range(10, phase_items[p] - 10);
      for (int i = 0; i < phase_items[p]; i++) begin
        // sender pauses until every outstanding read has come back
        if (i == hold_at)
          push_marker(WORD_HOLD, 0);
        add_random_word();
      end
    end

    // single reset, released after the stimulus queue is built
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // wait for the queue to drain and every read to return, evaluated off the edge
    while (!timed_out && !(pending_words.size() == 0 && !start_i && !cfg_we_i &&
                           expected_pixels.size() == 0)) begin
      @(negedge clk_i);
      if (quiet_cycles >= QUIET_LIMIT)
        timed_out = 1'b1;
    end
    if (!timed_out)
      repeat (DRAIN_CYCLES) @(negedge clk_i);

    if (!timed_out && failures == 0 && expected_pixels.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
